// ===== rtl/core/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// Eye pixel compositor package
// Payload types, table and region codes, register map and fixed constants
// shared by the compositor and its checker.
// ----------------------------------------------------------------------------
package epc_pkg;

    // default geometry
    localparam int unsigned SCREEN_SIZE_DEF   = 240;
    localparam int unsigned SCLERA_SIZE_DEF   = 375;
    localparam int unsigned IRIS_SIZE_DEF     = 150;
    localparam int unsigned IRIS_MAP_ROWS_DEF = 64;
    localparam int unsigned IRIS_MAP_COLS_DEF = 256;

    // polar word layout: distance in the low bits, angle above it
    localparam int unsigned DIST_W      = 7;
    localparam int unsigned ANGLE_W     = 9;
    localparam int unsigned ANGLE_SHIFT = 9;    // angle scale divides by 512

    // sclera coordinate: offset plus pixel, both 8 bits
    localparam int unsigned COORD_W = 9;
    localparam int unsigned IX_W    = 11;

    // scaled distance divided by 240 through a reciprocal multiply;
    // the quotient is exact for products below 2^24 / 224, which covers
    // every product below rows * 240 for up to 128 rows
    localparam int unsigned DIST_DIV   = 240;
    localparam int unsigned PROD_W     = 17;
    localparam int unsigned DIST_IN_W  = 15;
    localparam int unsigned DIST_SHIFT = 24;
    localparam int unsigned DIST_RECIP = (2 ** DIST_SHIFT + DIST_DIV - 1) / DIST_DIV;
    localparam int unsigned QUOT_W     = 32;

    // table write address compare width
    localparam int unsigned TADDR_CMP_W = 19;

    // item modes
    localparam logic MODE_RENDER = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    // table selects
    localparam logic [2:0] TBL_LOWER_LID = 3'd0;
    localparam logic [2:0] TBL_UPPER_LID = 3'd1;
    localparam logic [2:0] TBL_SCLERA    = 3'd2;
    localparam logic [2:0] TBL_POLAR     = 3'd3;
    localparam logic [2:0] TBL_IRIS_TEX  = 3'd4;

    // register map, byte address 4 * index
    localparam int unsigned CFG_ADDR_W   = 5;
    localparam logic [2:0] CFG_IRIS_SCALE = 3'd0;
    localparam logic [2:0] CFG_SCLERA_X   = 3'd1;
    localparam logic [2:0] CFG_SCLERA_Y   = 3'd2;
    localparam logic [2:0] CFG_UPPER_THR  = 3'd3;
    localparam logic [2:0] CFG_LOWER_THR  = 3'd4;

    localparam logic [9:0] IRIS_SCALE_RST = 10'd200;

    typedef enum logic [1:0] {
        REGION_LID        = 2'd0,
        REGION_SCLERA     = 2'd1,
        REGION_IRIS       = 2'd2,
        REGION_WRITE_DONE = 2'd3
    } t_region;

    typedef struct packed {
        logic        mode;
        logic [2:0]  table_select;
        logic [17:0] table_address;
        logic [15:0] table_data;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] pixel_color;
        t_region     region;
    } t_pixel_out;

endpackage

// ===== rtl/core/eye_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// Eye pixel compositor
// Takes one item per clock when the output side keeps up: a render item
// gives a screen pixel and comes back as a byte-swapped RGB565 color with
// its region; a load item writes one entry of the lid, sclera, polar or
// iris texture table. The pipeline is nine registers deep, from the input
// register to the output; an output stall holds each full stage. The
// depth is set by the chain of registered table reads: both lid maps, then
// the sclera image and polar map, then the iris texture addressed by the
// scaled distance, with the scale multiply and the divide by 240 as
// reciprocal multiply between them. Table contents hold no reset value; each
// entry must be written before a render item reads it. Registers on the
// APB port may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module eye_pixel_compositor #(
    parameter int unsigned SCREEN_SIZE   = epc_pkg::SCREEN_SIZE_DEF,
    parameter int unsigned SCLERA_SIZE   = epc_pkg::SCLERA_SIZE_DEF,
    parameter int unsigned IRIS_SIZE     = epc_pkg::IRIS_SIZE_DEF,
    parameter int unsigned IRIS_MAP_ROWS = epc_pkg::IRIS_MAP_ROWS_DEF,
    parameter int unsigned IRIS_MAP_COLS = epc_pkg::IRIS_MAP_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // render and load items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  epc_pkg::t_pixel_in            i_in_data,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output epc_pkg::t_pixel_out           o_out_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [epc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned LID_DEPTH = SCREEN_SIZE * SCREEN_SIZE;
    localparam int unsigned SCL_DEPTH = SCLERA_SIZE * SCLERA_SIZE;
    localparam int unsigned POL_DEPTH = IRIS_SIZE * IRIS_SIZE;
    localparam int unsigned TEX_DEPTH = IRIS_MAP_ROWS * IRIS_MAP_COLS;
    localparam int unsigned LID_AW    = $clog2(LID_DEPTH);
    localparam int unsigned SCL_AW    = $clog2(SCL_DEPTH);
    localparam int unsigned POL_AW    = $clog2(POL_DEPTH);
    localparam int unsigned TEX_AW    = $clog2(TEX_DEPTH);
    localparam int unsigned IR_W      = $clog2(IRIS_SIZE);
    localparam int unsigned ROW_W     = $clog2(IRIS_MAP_ROWS);
    localparam int unsigned COL_W     = $clog2(IRIS_MAP_COLS);
    localparam int unsigned ANG_PW    = epc_pkg::ANGLE_W + epc_pkg::ANGLE_SHIFT + 2;
    localparam int          MARGIN    = (int'(SCLERA_SIZE) - int'(IRIS_SIZE)) / 2;
    localparam int unsigned DIST_LIM  = IRIS_MAP_ROWS * epc_pkg::DIST_DIV;
    localparam int unsigned NSTG      = 9;
    localparam int unsigned CW        = epc_pkg::COORD_W;
    localparam int unsigned AC        = epc_pkg::TADDR_CMP_W;

    // configuration registers
    logic [9:0] r_iris_scale;
    logic [7:0] r_sclera_x;
    logic [7:0] r_sclera_y;
    logic [7:0] r_upper_thr;
    logic [7:0] r_lower_thr;

    // stage control
    logic [NSTG:1] adv;
    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;

    // table storage
    logic [7:0]  r_lower_mem [LID_DEPTH];
    logic [7:0]  r_upper_mem [LID_DEPTH];
    logic [15:0] r_sclera_mem [SCL_DEPTH];
    logic [15:0] r_polar_mem [POL_DEPTH];
    logic [15:0] r_tex_mem [TEX_DEPTH];

    // stage 1: input register
    epc_pkg::t_pixel_in r_s1_item;

    // stage 2: coordinates
    epc_pkg::t_pixel_in r_s2_item;
    logic               r_s2_off, n_s2_off;
    logic [LID_AW-1:0]  r_s2_lid_idx, n_s2_lid_idx;
    logic [CW-1:0]      r_s2_csx, n_s2_csx;
    logic [CW-1:0]      r_s2_csy, n_s2_csy;
    logic               r_s2_win, n_s2_win;
    logic [IR_W-1:0]    r_s2_ix, n_s2_ix;
    logic [IR_W-1:0]    r_s2_iy, n_s2_iy;
    logic [CW-1:0]      w_sx, w_sy;
    logic [epc_pkg::IX_W-1:0] w_ix, w_iy;

    // stage 3: lid data, sclera and polar addresses
    epc_pkg::t_pixel_in r_s3_item;
    logic               r_s3_off;
    logic               r_s3_win;
    logic [7:0]         r_s3_lo;
    logic [7:0]         r_s3_up;
    logic [SCL_AW-1:0]  r_s3_scl_idx, n_s3_scl_idx;
    logic [POL_AW-1:0]  r_s3_pol_idx, n_s3_pol_idx;

    // stage 4: sclera and polar data, lid decision
    epc_pkg::t_pixel_in r_s4_item;
    logic               r_s4_hide, n_s4_hide;
    logic               r_s4_win;
    logic [15:0]        r_s4_scl;
    logic [15:0]        r_s4_pol;

    // stage 5: scaled distance and angle column
    epc_pkg::t_pixel_in r_s5_item;
    logic               r_s5_hide;
    logic               r_s5_win;
    logic [15:0]        r_s5_scl;
    logic [epc_pkg::PROD_W-1:0] r_s5_prod, n_s5_prod;
    logic [COL_W-1:0]   r_s5_ang, n_s5_ang;
    logic [ANG_PW-1:0]  w_ang_full;

    // stage 6: reciprocal product
    epc_pkg::t_pixel_in r_s6_item;
    logic               r_s6_hide;
    logic               r_s6_win;
    logic [15:0]        r_s6_scl;
    logic [COL_W-1:0]   r_s6_ang;
    logic               r_s6_in_rng, n_s6_in_rng;
    logic [epc_pkg::QUOT_W-1:0] r_s6_q, n_s6_q;

    // stage 7: texture address
    epc_pkg::t_pixel_in r_s7_item;
    logic               r_s7_hide;
    logic               r_s7_iris, n_s7_iris;
    logic [15:0]        r_s7_scl;
    logic [TEX_AW-1:0]  r_s7_tex_idx, n_s7_tex_idx;
    logic [ROW_W-1:0]   w_dist;

    // stage 8: texture data
    logic               r_s8_mode;
    logic               r_s8_hide;
    logic               r_s8_iris;
    logic [15:0]        r_s8_scl;
    logic [15:0]        r_s8_tex;

    // stage 9: output register
    epc_pkg::t_pixel_out r_out, n_out;
    logic [15:0]         w_color;

    // table write strobes, each at the stage that reads the same table
    logic w_lo_we, w_up_we, w_scl_we, w_pol_we, w_tex_we;

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    // register write at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iris_scale <= epc_pkg::IRIS_SCALE_RST;
            r_sclera_x   <= '0;
            r_sclera_y   <= '0;
            r_upper_thr  <= '0;
            r_lower_thr  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[epc_pkg::CFG_ADDR_W-1:2])
                epc_pkg::CFG_IRIS_SCALE: r_iris_scale <= pwdata[9:0];
                epc_pkg::CFG_SCLERA_X:   r_sclera_x   <= pwdata[7:0];
                epc_pkg::CFG_SCLERA_Y:   r_sclera_y   <= pwdata[7:0];
                epc_pkg::CFG_UPPER_THR:  r_upper_thr  <= pwdata[7:0];
                epc_pkg::CFG_LOWER_THR:  r_lower_thr  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (paddr[epc_pkg::CFG_ADDR_W-1:2])
            epc_pkg::CFG_IRIS_SCALE: prdata = 32'(r_iris_scale);
            epc_pkg::CFG_SCLERA_X:   prdata = 32'(r_sclera_x);
            epc_pkg::CFG_SCLERA_Y:   prdata = 32'(r_sclera_y);
            epc_pkg::CFG_UPPER_THR:  prdata = 32'(r_upper_thr);
            epc_pkg::CFG_LOWER_THR:  prdata = 32'(r_lower_thr);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------------
    always_comb begin
        adv[NSTG] = !r_vld[NSTG] || i_out_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld[1] = adv[1] ? i_in_valid : r_vld[1];
        for (int k = 2; k <= NSTG; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = adv[1];
    assign o_out_valid = r_vld[NSTG];
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // stage 1 -> 2: screen check, sclera coordinates, iris window
    // ------------------------------------------------------------------------
    always_comb begin
        n_s2_off = ({1'b0, r_s1_item.pixel_x} >= 9'(SCREEN_SIZE)) ||
                   ({1'b0, r_s1_item.pixel_y} >= 9'(SCREEN_SIZE));
        n_s2_lid_idx = LID_AW'(LID_AW'(r_s1_item.pixel_y) * LID_AW'(SCREEN_SIZE)
                               + LID_AW'(r_s1_item.pixel_x));
        w_sx = CW'(r_sclera_x) + CW'(r_s1_item.pixel_x);
        w_sy = CW'(r_sclera_y) + CW'(r_s1_item.pixel_y);
        n_s2_csx = ({1'b0, w_sx} >= (CW+1)'(SCLERA_SIZE)) ? CW'(SCLERA_SIZE - 1) : w_sx;
        n_s2_csy = ({1'b0, w_sy} >= (CW+1)'(SCLERA_SIZE)) ? CW'(SCLERA_SIZE - 1) : w_sy;
        // iris window position from the unclamped sclera coordinate
        w_ix = epc_pkg::IX_W'(w_sx) - epc_pkg::IX_W'(MARGIN);
        w_iy = epc_pkg::IX_W'(w_sy) - epc_pkg::IX_W'(MARGIN);
        n_s2_win = !w_ix[epc_pkg::IX_W-1] && (w_ix < epc_pkg::IX_W'(IRIS_SIZE)) &&
                   !w_iy[epc_pkg::IX_W-1] && (w_iy < epc_pkg::IX_W'(IRIS_SIZE));
        n_s2_ix = w_ix[IR_W-1:0];
        n_s2_iy = w_iy[IR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_item <= i_in_data;
        end
        if (adv[2]) begin
            r_s2_item    <= r_s1_item;
            r_s2_off     <= n_s2_off;
            r_s2_lid_idx <= n_s2_lid_idx;
            r_s2_csx     <= n_s2_csx;
            r_s2_csy     <= n_s2_csy;
            r_s2_win     <= n_s2_win;
            r_s2_ix      <= n_s2_ix;
            r_s2_iy      <= n_s2_iy;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2 -> 3: lid map access, sclera and polar addresses
    // ------------------------------------------------------------------------
    always_comb begin
        w_lo_we = adv[3] && r_vld[2] && (r_s2_item.mode == epc_pkg::MODE_WRITE) &&
                  (r_s2_item.table_select == epc_pkg::TBL_LOWER_LID) &&
                  (AC'(r_s2_item.table_address) < AC'(LID_DEPTH));
        w_up_we = adv[3] && r_vld[2] && (r_s2_item.mode == epc_pkg::MODE_WRITE) &&
                  (r_s2_item.table_select == epc_pkg::TBL_UPPER_LID) &&
                  (AC'(r_s2_item.table_address) < AC'(LID_DEPTH));
        n_s3_scl_idx = SCL_AW'(SCL_AW'(r_s2_csy) * SCL_AW'(SCLERA_SIZE) + SCL_AW'(r_s2_csx));
        n_s3_pol_idx = POL_AW'(POL_AW'(r_s2_iy) * POL_AW'(IRIS_SIZE) + POL_AW'(r_s2_ix));
    end

    // lid maps
    always_ff @(posedge i_clk) begin
        if (w_lo_we) begin
            r_lower_mem[r_s2_item.table_address[LID_AW-1:0]] <= r_s2_item.table_data[7:0];
        end
        if (w_up_we) begin
            r_upper_mem[r_s2_item.table_address[LID_AW-1:0]] <= r_s2_item.table_data[7:0];
        end
        if (adv[3]) begin
            r_s3_lo <= r_lower_mem[r_s2_lid_idx];
            r_s3_up <= r_upper_mem[r_s2_lid_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s3_item    <= r_s2_item;
            r_s3_off     <= r_s2_off;
            r_s3_win     <= r_s2_win;
            r_s3_scl_idx <= n_s3_scl_idx;
            r_s3_pol_idx <= n_s3_pol_idx;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3 -> 4: lid decision, sclera and polar access
    // ------------------------------------------------------------------------
    always_comb begin
        n_s4_hide = r_s3_off || (r_s3_lo <= r_lower_thr) || (r_s3_up <= r_upper_thr);
        w_scl_we = adv[4] && r_vld[3] && (r_s3_item.mode == epc_pkg::MODE_WRITE) &&
                   (r_s3_item.table_select == epc_pkg::TBL_SCLERA) &&
                   (AC'(r_s3_item.table_address) < AC'(SCL_DEPTH));
        w_pol_we = adv[4] && r_vld[3] && (r_s3_item.mode == epc_pkg::MODE_WRITE) &&
                   (r_s3_item.table_select == epc_pkg::TBL_POLAR) &&
                   (AC'(r_s3_item.table_address) < AC'(POL_DEPTH));
    end

    // sclera image
    always_ff @(posedge i_clk) begin
        if (w_scl_we) begin
            r_sclera_mem[r_s3_item.table_address[SCL_AW-1:0]] <= r_s3_item.table_data;
        end
        if (adv[4]) begin
            r_s4_scl <= r_sclera_mem[r_s3_scl_idx];
        end
    end

    // polar map
    always_ff @(posedge i_clk) begin
        if (w_pol_we) begin
            r_polar_mem[r_s3_item.table_address[POL_AW-1:0]] <= r_s3_item.table_data;
        end
        if (adv[4]) begin
            r_s4_pol <= r_polar_mem[r_s3_pol_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s4_item <= r_s3_item;
            r_s4_hide <= n_s4_hide;
            r_s4_win  <= r_s3_win;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4 -> 5: distance times scale, angle to texture column
    // ------------------------------------------------------------------------
    always_comb begin
        n_s5_prod  = epc_pkg::PROD_W'(r_iris_scale) *
                     epc_pkg::PROD_W'(r_s4_pol[epc_pkg::DIST_W-1:0]);
        w_ang_full = ANG_PW'(r_s4_pol[15:epc_pkg::DIST_W]) * ANG_PW'(IRIS_MAP_COLS);
        n_s5_ang   = w_ang_full[epc_pkg::ANGLE_SHIFT +: COL_W];
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s5_item <= r_s4_item;
            r_s5_hide <= r_s4_hide;
            r_s5_win  <= r_s4_win;
            r_s5_scl  <= r_s4_scl;
            r_s5_prod <= n_s5_prod;
            r_s5_ang  <= n_s5_ang;
        end
    end

    // ------------------------------------------------------------------------
    // stage 5 -> 6: row range check and reciprocal multiply for the divide
    // ------------------------------------------------------------------------
    always_comb begin
        n_s6_in_rng = r_s5_prod < epc_pkg::PROD_W'(DIST_LIM);
        n_s6_q = epc_pkg::QUOT_W'(r_s5_prod[epc_pkg::DIST_IN_W-1:0]) *
                 epc_pkg::QUOT_W'(epc_pkg::DIST_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s6_item   <= r_s5_item;
            r_s6_hide   <= r_s5_hide;
            r_s6_win    <= r_s5_win;
            r_s6_scl    <= r_s5_scl;
            r_s6_ang    <= r_s5_ang;
            r_s6_in_rng <= n_s6_in_rng;
            r_s6_q      <= n_s6_q;
        end
    end

    // ------------------------------------------------------------------------
    // stage 6 -> 7: texture address from row and column
    // ------------------------------------------------------------------------
    always_comb begin
        w_dist       = r_s6_q[epc_pkg::DIST_SHIFT +: ROW_W];
        n_s7_tex_idx = TEX_AW'(TEX_AW'(w_dist) * TEX_AW'(IRIS_MAP_COLS) + TEX_AW'(r_s6_ang));
        n_s7_iris    = r_s6_win && r_s6_in_rng;
    end

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s7_item    <= r_s6_item;
            r_s7_hide    <= r_s6_hide;
            r_s7_iris    <= n_s7_iris;
            r_s7_scl     <= r_s6_scl;
            r_s7_tex_idx <= n_s7_tex_idx;
        end
    end

    // ------------------------------------------------------------------------
    // stage 7 -> 8: iris texture access
    // ------------------------------------------------------------------------
    assign w_tex_we = adv[8] && r_vld[7] && (r_s7_item.mode == epc_pkg::MODE_WRITE) &&
                      (r_s7_item.table_select == epc_pkg::TBL_IRIS_TEX) &&
                      (AC'(r_s7_item.table_address) < AC'(TEX_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_tex_we) begin
            r_tex_mem[r_s7_item.table_address[TEX_AW-1:0]] <= r_s7_item.table_data;
        end
        if (adv[8]) begin
            r_s8_tex <= r_tex_mem[r_s7_tex_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_s8_mode <= r_s7_item.mode;
            r_s8_hide <= r_s7_hide;
            r_s8_iris <= r_s7_iris;
            r_s8_scl  <= r_s7_scl;
        end
    end

    // ------------------------------------------------------------------------
    // stage 8 -> 9: color select and byte swap
    // ------------------------------------------------------------------------
    always_comb begin
        if (r_s8_mode == epc_pkg::MODE_WRITE) begin
            w_color      = '0;
            n_out.region = epc_pkg::REGION_WRITE_DONE;
        end else if (r_s8_hide) begin
            w_color      = '0;
            n_out.region = epc_pkg::REGION_LID;
        end else if (r_s8_iris) begin
            w_color      = r_s8_tex;
            n_out.region = epc_pkg::REGION_IRIS;
        end else begin
            w_color      = r_s8_scl;
            n_out.region = epc_pkg::REGION_SCLERA;
        end
        n_out.pixel_color = {w_color[7:0], w_color[15:8]};
    end

    always_ff @(posedge i_clk) begin
        if (adv[NSTG]) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/core/epc_checker.sv =====
// ----------------------------------------------------------------------------
// Eye pixel compositor checker
// Port-level checks on the result channel and the pipeline back pressure,
// bound to every instance of the compositor.
// ----------------------------------------------------------------------------
module epc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input epc_pkg::t_pixel_out o_out_data
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // an empty output register means the whole pipeline can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register empty");

    // load acknowledges and eyelid pixels carry black
    a_black_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.region == epc_pkg::REGION_WRITE_DONE ||
                        o_out_data.region == epc_pkg::REGION_LID)
        |-> o_out_data.pixel_color == 16'd0)
        else $error("nonzero color on a black or write result");

endmodule

bind eye_pixel_compositor epc_checker u_epc_checker (.*);
